// ===== src/nmeagga_pkg.sv =====
`timescale 1ns / 1ps
// shared types, character codes and small tables for the gga position parser
// no dependencies

package nmeagga_pkg;

  // default number of fraction digits of the minutes field
  localparam int unsigned FRAC_DIGITS_DEF = 4;

  // record queue depth between the byte parser and the converter
  localparam int unsigned Q_DEPTH = 2;

  // widths of the integer parts of one coordinate
  localparam int unsigned DEG_W = 10;  // up to three degree digits
  localparam int unsigned MIN_W = 7;   // two minute digits

  // result field widths
  localparam int unsigned LAT_W = 28;
  localparam int unsigned LON_W = 31;

  // lane order inside packed coordinate pairs
  localparam int unsigned LANE_LAT = 0;
  localparam int unsigned LANE_LON = 1;

  localparam int unsigned MICRO = 1000000;

  // integer digit limits, counted as positions in the field
  localparam logic [3:0] LAT_INT_MAX = 4'd4;
  localparam logic [3:0] LON_INT_MAX = 4'd5;

  // field numbers and counter limits
  localparam logic [3:0] FLD_HDR  = 4'd0;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_MAX  = 4'd15;
  localparam logic [3:0] POS_MAX  = 4'd15;
  localparam logic [3:0] HDR_LEN  = 4'd5;
  localparam logic [3:0] CK_DIGITS  = 4'd2;
  localparam logic [3:0] CK_INVALID = 4'd3;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // result status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_CKSUM   = 2'd1;
  localparam logic [1:0] ST_NOT_GGA = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_BODY,
    PH_CKSUM
  } phase_e;

  // per-sentence flags handed from the parser to the converter
  typedef struct packed {
    logic [1:0] status;
    logic       south;
    logic       west;
  } rec_ctrl_t;

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned p;
    unique case (n)
      0: p = 1;
      1: p = 10;
      2: p = 100;
      3: p = 1000;
      4: p = 10000;
      5: p = 100000;
      6: p = 1000000;
      default: p = 1;
    endcase
    return p;
  endfunction

  // expected sentence header, one character per position
  function automatic logic [7:0] hdr_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0: ch = 8'h47;
      4'd1: ch = 8'h50;
      4'd2: ch = 8'h47;
      4'd3: ch = 8'h47;
      4'd4: ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 4 flags a hex digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= CH_0 && c <= CH_9) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF_HEX)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end else begin
      v = 5'd0;
    end
    return v;
  endfunction

endpackage

// ===== src/nmeagga_front.sv =====
`timescale 1ns / 1ps
// byte parser: sentence framing, checksum, header check and digit collection
// depends on nmeagga_pkg

module nmeagga_front #(
  parameter int unsigned FracDigits = nmeagga_pkg::FRAC_DIGITS_DEF,
  localparam int unsigned FracW = $clog2(nmeagga_pkg::pow10(FracDigits))
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      byte_valid_i,
  input  logic [7:0]                                char_i,
  output logic                                      push_o,
  output nmeagga_pkg::rec_ctrl_t                    rec_ctrl_o,
  output logic [1:0][nmeagga_pkg::DEG_W-1:0]        rec_deg_o,
  output logic [1:0][nmeagga_pkg::MIN_W-1:0]        rec_min_o,
  output logic [1:0][FracW-1:0]                     rec_frac_o
);
  import nmeagga_pkg::*;

  localparam int unsigned FcW = $clog2(FracDigits + 1);

  phase_e                 phase_q, phase_d;
  logic [7:0]             xor_q, xor_d;
  logic [3:0]             fld_q, fld_d;
  logic [3:0]             pos_q, pos_d;
  logic                   hdr_ok_q, hdr_ok_d;
  logic [1:0][DEG_W-1:0]  hi_q, hi_d;
  logic [1:0][3:0]        tens_q, tens_d;
  logic [1:0][3:0]        ones_q, ones_d;
  logic [1:0][FracW-1:0]  frac_q, frac_d;
  logic [FcW-1:0]         fcnt_q, fcnt_d;
  logic                   point_q, point_d;
  logic                   south_q, south_d;
  logic                   west_q, west_d;
  logic [7:0]             ck_q, ck_d;
  logic                   star_q, star_d;

  logic                   is_eol;
  logic                   is_digit;
  logic [3:0]             digit;
  logic                   hdr_close_bad;
  logic                   hdr_eff;
  logic [4:0]             hex;
  logic [FracW-1:0]       frac_add;
  logic [1:0]             lane_on;
  logic [1:0][3:0]        lane_lim;
  logic                   clear;
  logic [1:0]             status_w;

  assign is_eol   = (char_i == CH_CR) || (char_i == CH_LF);
  assign is_digit = (char_i >= CH_0) && (char_i <= CH_9);
  assign digit    = char_i[3:0];
  assign hex      = hex_val(char_i);
  assign frac_add = FracW'(pow10(FracDigits - 32'(fcnt_q) - 1) * 32'(digit));

  assign lane_on[LANE_LAT]  = (fld_q == FLD_LAT);
  assign lane_on[LANE_LON]  = (fld_q == FLD_LON);
  assign lane_lim[LANE_LAT] = LAT_INT_MAX;
  assign lane_lim[LANE_LON] = LON_INT_MAX;

  // header field closes short or long
  assign hdr_close_bad = (fld_q == FLD_HDR) && (pos_q != HDR_LEN);
  assign hdr_eff       = hdr_ok_q && !((phase_q == PH_BODY) && hdr_close_bad);

  always_comb begin
    if (!hdr_eff || !star_q) begin
      status_w = ST_NOT_GGA;
    end else if ((pos_q != CK_DIGITS) || (ck_q != xor_q)) begin
      status_w = ST_CKSUM;
    end else begin
      status_w = ST_VALID;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (byte_valid_i) begin
      if (char_i == CH_DOLLAR) begin
        phase_d = PH_BODY;
      end else begin
        unique case (phase_q)
          PH_WAIT: phase_d = PH_WAIT;
          PH_BODY: begin
            if (is_eol) begin
              phase_d = PH_WAIT;
            end else if (char_i == CH_STAR) begin
              phase_d = PH_CKSUM;
            end
          end
          PH_CKSUM: begin
            if (is_eol) begin
              phase_d = PH_WAIT;
            end
          end
          default: phase_d = PH_WAIT;
        endcase
      end
    end
  end

  // sentence datapath
  always_comb begin
    xor_d    = xor_q;
    fld_d    = fld_q;
    pos_d    = pos_q;
    hdr_ok_d = hdr_ok_q;
    hi_d     = hi_q;
    tens_d   = tens_q;
    ones_d   = ones_q;
    frac_d   = frac_q;
    fcnt_d   = fcnt_q;
    point_d  = point_q;
    south_d  = south_q;
    west_d   = west_q;
    ck_d     = ck_q;
    star_d   = star_q;
    clear    = 1'b0;
    push_o   = 1'b0;

    if (byte_valid_i) begin
      if (char_i == CH_DOLLAR) begin
        clear = 1'b1;
      end else if (phase_q == PH_WAIT) begin
        clear = 1'b0;
      end else if (is_eol) begin
        push_o = 1'b1;
        clear  = 1'b1;
      end else if (phase_q == PH_CKSUM) begin
        if (hex[4] && (pos_q < CK_DIGITS)) begin
          ck_d  = {ck_q[3:0], hex[3:0]};
          pos_d = pos_q + 4'd1;
        end else begin
          pos_d = CK_INVALID;
        end
      end else if (char_i == CH_STAR) begin
        if (hdr_close_bad) begin
          hdr_ok_d = 1'b0;
        end
        star_d = 1'b1;
        pos_d  = '0;
      end else begin
        xor_d = xor_q ^ char_i;
        if (char_i == CH_COMMA) begin
          if (hdr_close_bad) begin
            hdr_ok_d = 1'b0;
          end
          if (fld_q < FLD_MAX) begin
            fld_d = fld_q + 4'd1;
          end
          pos_d   = '0;
          point_d = 1'b0;
          fcnt_d  = '0;
        end else begin
          unique case (fld_q)
            FLD_HDR: begin
              if ((pos_q >= HDR_LEN) || (char_i != hdr_char(pos_q))) begin
                hdr_ok_d = 1'b0;
              end
            end
            FLD_NS: begin
              if (pos_q == '0) begin
                south_d = (char_i == CH_S);
              end
            end
            FLD_EW: begin
              if (pos_q == '0) begin
                west_d = (char_i == CH_W);
              end
            end
            default: hdr_ok_d = hdr_ok_q;
          endcase
          // coordinate digits: last two integer digits are the minutes
          for (int l = 0; l < 2; l++) begin
            if (lane_on[l]) begin
              if (is_digit) begin
                if (!point_q) begin
                  if (pos_q < lane_lim[l]) begin
                    hi_d[l]   = hi_q[l] * DEG_W'(10) + DEG_W'(tens_q[l]);
                    tens_d[l] = ones_q[l];
                    ones_d[l] = digit;
                  end
                end else if (fcnt_q < FcW'(FracDigits)) begin
                  frac_d[l] = frac_q[l] + frac_add;
                  fcnt_d    = fcnt_q + FcW'(1);
                end
              end else if (char_i == CH_POINT) begin
                point_d = 1'b1;
              end
            end
          end
          if (pos_q < POS_MAX) begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
    end

    if (clear) begin
      xor_d    = '0;
      fld_d    = '0;
      pos_d    = '0;
      hdr_ok_d = 1'b1;
      hi_d     = '0;
      tens_d   = '0;
      ones_d   = '0;
      frac_d   = '0;
      fcnt_d   = '0;
      point_d  = 1'b0;
      south_d  = 1'b0;
      west_d   = 1'b0;
      ck_d     = '0;
      star_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      xor_q    <= '0;
      fld_q    <= '0;
      pos_q    <= '0;
      hdr_ok_q <= 1'b1;
      hi_q     <= '0;
      tens_q   <= '0;
      ones_q   <= '0;
      frac_q   <= '0;
      fcnt_q   <= '0;
      point_q  <= 1'b0;
      south_q  <= 1'b0;
      west_q   <= 1'b0;
      ck_q     <= '0;
      star_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      xor_q    <= xor_d;
      fld_q    <= fld_d;
      pos_q    <= pos_d;
      hdr_ok_q <= hdr_ok_d;
      hi_q     <= hi_d;
      tens_q   <= tens_d;
      ones_q   <= ones_d;
      frac_q   <= frac_d;
      fcnt_q   <= fcnt_d;
      point_q  <= point_d;
      south_q  <= south_d;
      west_q   <= west_d;
      ck_q     <= ck_d;
      star_q   <= star_d;
    end
  end

  assign rec_ctrl_o = '{status: status_w, south: south_q, west: west_q};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rec_deg_o[l]  = hi_q[l];
      rec_min_o[l]  = MIN_W'(tens_q[l]) * MIN_W'(10) + MIN_W'(ones_q[l]);
      rec_frac_o[l] = frac_q[l];
    end
  end

endmodule

// ===== src/nmeagga_fifo.sv =====
`timescale 1ns / 1ps
// small register queue for finished sentence records
// depends on nmeagga_pkg

module nmeagga_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = nmeagga_pkg::Q_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] din_i,
  input  logic             pop_i,
  output logic [Width-1:0] dout_o,
  output logic             empty_o,
  output logic             full_o
);
  import nmeagga_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// ===== src/nmeagga_conv.sv =====
`timescale 1ns / 1ps
// four-stage converter from degrees, minutes and minute fraction to microdegrees
// depends on nmeagga_pkg

module nmeagga_conv #(
  parameter int unsigned FracDigits = nmeagga_pkg::FRAC_DIGITS_DEF,
  localparam int unsigned FracW = $clog2(nmeagga_pkg::pow10(FracDigits))
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 head_valid_i,
  output logic                                 pop_o,
  input  nmeagga_pkg::rec_ctrl_t               ctrl_i,
  input  logic [1:0][nmeagga_pkg::DEG_W-1:0]   deg_i,
  input  logic [1:0][nmeagga_pkg::MIN_W-1:0]   min_i,
  input  logic [1:0][FracW-1:0]                frac_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [nmeagga_pkg::LAT_W-1:0] lat_o,
  output logic signed [nmeagga_pkg::LON_W-1:0] lon_o
);
  import nmeagga_pkg::*;

  localparam int unsigned FracK      = MICRO / pow10(FracDigits);
  localparam int unsigned N_W        = 27;  // minutes scaled by 1e6, below 1e8
  localparam int unsigned X_W        = 25;  // that value over 4
  localparam int unsigned DEGM_W     = 30;
  localparam int unsigned PROD_W     = 2 * X_W;
  localparam int unsigned Q_W        = 21;
  localparam int unsigned RES_W      = 31;
  localparam int unsigned RecipShift = 28;
  localparam logic [X_W-1:0] RecipMul = X_W'((64'd1 << RecipShift) / 64'd15);

  logic adv;

  logic                     s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  rec_ctrl_t                s1_ctrl_q, s2_ctrl_q, s3_ctrl_q;
  logic [1:0][DEGM_W-1:0]   s1_degm_q, s1_degm_d, s2_degm_q, s3_degm_q;
  logic [1:0][X_W-1:0]      s1_x_q, s1_x_d, s2_x_q;
  logic [1:0][PROD_W-1:0]   s2_prod_q, s2_prod_d;
  logic [1:0][Q_W-1:0]      s3_quo_q, s3_quo_d;
  logic [1:0][N_W-1:0]      n_w;
  logic [1:0][Q_W-1:0]      q0_w;
  logic [1:0][X_W-1:0]      q0x_w, rem_w;
  logic [1:0][RES_W-1:0]    res_w, res_d;
  logic [1:0]               status_d;
  logic [1:0][RES_W-1:0]    res_q;
  logic [1:0]               status_q;

  // whole pipe moves unless the output holds a result that is stalled
  assign adv   = !s4_v_q || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      // stage 1: minutes as 1e6 * min + frac * 1e6 / scale, then drop two bits of /60
      n_w[l]       = N_W'(min_i[l]) * N_W'(MICRO) + N_W'(frac_i[l]) * N_W'(FracK);
      s1_x_d[l]    = n_w[l][N_W-1:2];
      s1_degm_d[l] = DEGM_W'(deg_i[l]) * DEGM_W'(MICRO);
      // stage 2: reciprocal multiply for /15
      s2_prod_d[l] = PROD_W'(s1_x_q[l]) * PROD_W'(RecipMul);
      // stage 3: estimate is low by at most one, fix by remainder check
      q0_w[l]      = s2_prod_q[l][RecipShift +: Q_W];
      q0x_w[l]     = X_W'(q0_w[l]);
      rem_w[l]     = s2_x_q[l] - ((q0x_w[l] << 4) - q0x_w[l]);
      s3_quo_d[l]  = (rem_w[l] >= X_W'(15)) ? q0_w[l] + Q_W'(1) : q0_w[l];
      // stage 4: degrees plus minute part, sign by hemisphere
      res_w[l]     = RES_W'(s3_degm_q[l]) + RES_W'(s3_quo_q[l]);
    end
    res_d[LANE_LAT] = s3_ctrl_q.south ? -res_w[LANE_LAT] : res_w[LANE_LAT];
    res_d[LANE_LON] = s3_ctrl_q.west  ? -res_w[LANE_LON] : res_w[LANE_LON];
    if (s3_ctrl_q.status != ST_VALID) begin
      res_d = '0;
    end
    status_d = s3_ctrl_q.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= head_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctrl_q <= ctrl_i;
      s1_degm_q <= s1_degm_d;
      s1_x_q    <= s1_x_d;
      s2_ctrl_q <= s1_ctrl_q;
      s2_degm_q <= s1_degm_q;
      s2_x_q    <= s1_x_q;
      s2_prod_q <= s2_prod_d;
      s3_ctrl_q <= s2_ctrl_q;
      s3_degm_q <= s2_degm_q;
      s3_quo_q  <= s3_quo_d;
      res_q     <= res_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = s4_v_q;
  assign status_o    = status_q;
  assign lat_o       = res_q[LANE_LAT][LAT_W-1:0];
  assign lon_o       = res_q[LANE_LON][LON_W-1:0];

endmodule

// ===== src/nmea_gga_position_parser_unit.sv =====
`timescale 1ns / 1ps
// top level of the gga sentence position parser: parser, record queue, converter
// depends on nmeagga_pkg, nmeagga_front, nmeagga_fifo, nmeagga_conv
//
//   channel   direction  handshake                   payload
//   input     in         in_valid_i / in_stall_o     char_in_i (one text byte)
//   result    out        out_valid_o / out_stall_i   status_o, lat_microdeg_o, lon_microdeg_o
//
// one byte is taken per cycle while in_stall_o is low; a cr or lf that ends a sentence posts
// a record into a two-entry queue, and its result reaches the output through the converter
// pipeline of four registered stages
// in_stall_o rises only while the record queue is full, which the output side
// sets by how fast it drains results
// reset clears the parser and all valid bits at once; no clearing pass

module nmea_gga_position_parser_unit #(
  parameter int unsigned FracDigits = nmeagga_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           char_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [nmeagga_pkg::LAT_W-1:0] lat_microdeg_o,
  output logic signed [nmeagga_pkg::LON_W-1:0] lon_microdeg_o
);
  import nmeagga_pkg::*;

  localparam int unsigned FracW = $clog2(pow10(FracDigits));
  localparam int unsigned RecW  = $bits(rec_ctrl_t) + 2 * (DEG_W + MIN_W + FracW);

  // accepted byte strobe
  logic                  byte_valid;

  // record from the parser
  logic                  rec_push;
  rec_ctrl_t             rec_ctrl;
  logic [1:0][DEG_W-1:0] rec_deg;
  logic [1:0][MIN_W-1:0] rec_min;
  logic [1:0][FracW-1:0] rec_frac;

  // queue head toward the converter
  logic [RecW-1:0]       q_din, q_dout;
  logic                  q_empty, q_full, q_pop;
  rec_ctrl_t             head_ctrl;
  logic [1:0][DEG_W-1:0] head_deg;
  logic [1:0][MIN_W-1:0] head_min;
  logic [1:0][FracW-1:0] head_frac;

  // queue full is the only reason to hold back the byte stream
  assign in_stall_o = q_full;
  assign byte_valid = in_valid_i && !in_stall_o;

  nmeagga_front #(
    .FracDigits (FracDigits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .char_i       (char_in_i),
    .push_o       (rec_push),
    .rec_ctrl_o   (rec_ctrl),
    .rec_deg_o    (rec_deg),
    .rec_min_o    (rec_min),
    .rec_frac_o   (rec_frac)
  );

  assign q_din = {rec_ctrl, rec_deg, rec_min, rec_frac};

  nmeagga_fifo #(
    .Width (RecW),
    .Depth (Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .din_i   (q_din),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign {head_ctrl, head_deg, head_min, head_frac} = q_dout;

  nmeagga_conv #(
    .FracDigits (FracDigits)
  ) u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .ctrl_i       (head_ctrl),
    .deg_i        (head_deg),
    .min_i        (head_min),
    .frac_i       (head_frac),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .lat_o        (lat_microdeg_o),
    .lon_o        (lon_microdeg_o)
  );

  // a record is never posted into a full queue
  a_no_push_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) rec_push |-> !q_full
  ) else $error("record posted while queue full");

  // a posted record is held in the queue on the next cycle
  a_push_lands: assert property (
    @(posedge clk_i) disable iff (!rst_ni) rec_push |=> !q_empty
  ) else $error("posted record missing from queue");

  // failed sentences report a zero position
  a_zero_on_error: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_VALID)) |->
      ((lat_microdeg_o == '0) && (lon_microdeg_o == '0))
  ) else $error("nonzero position on failed sentence");

endmodule

// ===== bench/nmea_gga_position_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the gga position parser: sentence stimulus, result scoreboard
// depends on nmeagga_pkg and nmea_gga_position_parser_unit

module nmea_gga_position_parser_unit_tb;
  import nmeagga_pkg::*;

  // run limits
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_TAIL  = 8;   // converter pipeline plus record queue
  localparam int unsigned HOLD_CYCLES = 400;

  // how a sentence is closed off after its body
  typedef enum {
    CKS_UPPER,
    CKS_LOWER,
    CKS_WRONG,
    CKS_ONE,
    CKS_THREE,
    CKS_JUNK,
    CKS_NONE
  } cks_style_e;

  // digit content of a generated number
  typedef enum {
    FILL_RANDOM,
    FILL_NINES,
    FILL_ZEROS
  } fill_e;

  // sentence parser mirror plus the queue of position fixes still owed by the block
  class gga_scoreboard;
    typedef struct {
      logic [1:0]       status;
      logic [LAT_W-1:0] lat;
      logic [LON_W-1:0] lon;
    } fix_t;

    fix_t        fixes_due[$];
    int unsigned errors;

    string  gga_tag = "GPGGA";
    phase_e phase;
    logic [7:0]  xsum;
    logic [7:0]  rx_sum;
    logic [3:0]  fld;
    logic [3:0]  pos;
    logic [2:0]  nfrac;
    bit          hdr_ok;
    bit          point_seen;
    bit          south;
    bit          west;
    bit          star;
    logic [26:0] lat_acc;
    logic [29:0] lon_acc;

    function new();
      errors = 0;
      phase  = PH_WAIT;
      restart();
    endfunction

    function void restart();
      xsum       = '0;
      rx_sum     = '0;
      fld        = '0;
      pos        = '0;
      nfrac      = '0;
      hdr_ok     = 1'b1;
      point_seen = 1'b0;
      south      = 1'b0;
      west       = 1'b0;
      star       = 1'b0;
      lat_acc    = '0;
      lon_acc    = '0;
    endfunction

    // missing fraction digits count as zeros
    function logic [29:0] pad_minutes(logic [29:0] v);
      while (nfrac < FRAC_DIGITS_DEF) begin
        v = 30'(v * 10);
        nfrac++;
      end
      return v;
    endfunction

    function void end_field();
      if (fld == FLD_HDR && pos != HDR_LEN) hdr_ok = 1'b0;
      if (fld == FLD_LAT) lat_acc = 27'(pad_minutes(30'(lat_acc)));
      if (fld == FLD_LON) lon_acc = pad_minutes(lon_acc);
    endfunction

    // integer digits are limited by position, fraction digits by count
    function logic [29:0] take(logic [29:0] v, logic [7:0] c, logic [3:0] int_max);
      if (c >= CH_0 && c <= CH_9) begin
        if (!point_seen) begin
          if (pos < int_max) v = 30'(v * 10 + (c - CH_0));
        end else if (nfrac < FRAC_DIGITS_DEF) begin
          v = 30'(v * 10 + (c - CH_0));
          nfrac++;
        end
      end else if (c == CH_POINT) begin
        point_seen = 1'b1;
      end
      return v;
    endfunction

    // ddmm.ffff style number to microdegrees, truncated
    function longint unsigned to_udeg(longint unsigned v);
      longint unsigned scale;
      longint unsigned deg;
      longint unsigned rest;
      scale = 1;
      repeat (FRAC_DIGITS_DEF) scale *= 10;
      deg  = v / scale / 100;
      rest = v - deg * 100 * scale;
      return deg * 1000000 + rest * 1000000 / (60 * scale);
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
      if (c >= CH_LA && c <= CH_LF_HEX) return c - CH_LA + 10;
      return -1;
    endfunction

    function void note_char(logic [7:0] c);
      fix_t            f;
      int              h;
      longint unsigned lat_u;
      longint unsigned lon_u;
      if (c == CH_DOLLAR) begin
        restart();
        phase = PH_BODY;
        return;
      end
      if (phase == PH_WAIT) return;
      if (c == CH_CR || c == CH_LF) begin
        if (phase == PH_BODY) end_field();
        f.lat = '0;
        f.lon = '0;
        if (!hdr_ok || !star) begin
          f.status = ST_NOT_GGA;
        end else if (pos != CK_DIGITS || rx_sum != xsum) begin
          f.status = ST_CKSUM;
        end else begin
          f.status = ST_VALID;
          lat_u = to_udeg(lat_acc);
          lon_u = to_udeg(lon_acc);
          if (south) lat_u = -lat_u;
          if (west) lon_u = -lon_u;
          f.lat = lat_u[LAT_W-1:0];
          f.lon = lon_u[LON_W-1:0];
        end
        fixes_due.push_back(f);
        phase = PH_WAIT;
        restart();
        return;
      end
      if (phase == PH_CKSUM) begin
        h = hex_of(c);
        if (h >= 0 && pos < CK_DIGITS) begin
          rx_sum = {rx_sum[3:0], 4'(h)};
          pos++;
        end else begin
          pos = CK_INVALID;
        end
        return;
      end
      if (c == CH_STAR) begin
        end_field();
        phase = PH_CKSUM;
        star  = 1'b1;
        pos   = '0;
        return;
      end
      xsum ^= c;
      if (c == CH_COMMA) begin
        end_field();
        if (fld < FLD_MAX) fld++;
        pos        = '0;
        point_seen = 1'b0;
        nfrac      = '0;
        return;
      end
      case (fld)
        FLD_HDR: if (pos >= HDR_LEN || c != gga_tag[pos]) hdr_ok = 1'b0;
        FLD_LAT: lat_acc = 27'(take(30'(lat_acc), c, LAT_INT_MAX));
        FLD_NS:  if (pos == 0) south = (c == CH_S);
        FLD_LON: lon_acc = take(lon_acc, c, LON_INT_MAX);
        FLD_EW:  if (pos == 0) west = (c == CH_W);
        default: ;
      endcase
      if (pos < POS_MAX) pos++;
    endfunction

    function void check_fix(logic [1:0] st, logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon);
      fix_t f;
      if (fixes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d lat %0d lon %0d",
                 $time, st, $signed(lat), $signed(lon));
        return;
      end
      f = fixes_due.pop_front();
      if (st !== f.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, f.status, st);
      end
      if (lat !== f.lat) begin
        errors++;
        $display("%0t: lat_microdeg expected %0d actual %0d", $time, $signed(f.lat),
                 $signed(lat));
      end
      if (lon !== f.lon) begin
        errors++;
        $display("%0t: lon_microdeg expected %0d actual %0d", $time, $signed(f.lon),
                 $signed(lon));
      end
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic [7:0] char_in_i = '0;
  logic out_stall_i = 1'b0;

  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [1:0]              status_o;
  logic signed [LAT_W-1:0] lat_microdeg_o;
  logic signed [LON_W-1:0] lon_microdeg_o;

  gga_scoreboard sb;

  // traffic shaping knobs, in percent
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;    // long receiver hold-off, counted down by the stall process
  int unsigned sent_count = 0;   // accepted input transactions
  int unsigned cycle_count = 0;

  nmea_gga_position_parser_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .lat_microdeg_o (lat_microdeg_o),
    .lon_microdeg_o (lon_microdeg_o)
  );

  always #1 clk_i = ~clk_i;

  initial sb = new();

  // input side monitor: every accepted byte advances the mirror parser
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_char(char_in_i);
  end

  // output side monitor: every accepted result is checked against the oldest fix owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_fix(status_o, lat_microdeg_o,
                                                            lon_microdeg_o);
  end

  // receiver: random stalls, or a solid hold-off while hold_left runs down
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // one byte transaction; valid stays high into the next call when no gap follows
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
    if (n < 10) return CH_0 + n;
    return 8'((lower ? CH_LA : CH_UA) + n - 10);
  endfunction

  function automatic string hex_text(input logic [7:0] v, input bit lower);
    return $sformatf("%c%c", hex_digit(v[7:4], lower), hex_digit(v[3:0], lower));
  endfunction

  // printable byte that cannot split a sentence
  function automatic logic [7:0] rand_printable();
    logic [7:0] ch;
    do ch = 8'($urandom_range(8'h7e, 8'h21));
    while (ch == CH_DOLLAR || ch == CH_STAR || ch == CH_COMMA);
    return ch;
  endfunction

  function automatic string rand_digits(input int n, input fill_e fill);
    string      s;
    logic [7:0] d;
    int         i;
    s = "";
    for (i = 0; i < n; i++) begin
      case (fill)
        FILL_NINES: d = CH_9;
        FILL_ZEROS: d = CH_0;
        default:    d = 8'($urandom_range(CH_9, CH_0));
      endcase
      s = {s, $sformatf("%c", d)};
    end
    return s;
  endfunction

  // coordinate field: mostly well formed, sometimes short, long or with junk in it
  function automatic string rand_coord(input int int_len);
    string s;
    fill_e fill;
    int    r;
    int    k;
    r = $urandom_range(99);
    fill = (r < 10) ? FILL_NINES : (r < 15) ? FILL_ZEROS : FILL_RANDOM;
    s = rand_digits(($urandom_range(99) < 75) ? int_len : $urandom_range(int_len + 2), fill);
    if ($urandom_range(99) < 85) begin
      s = {s, ".", rand_digits(($urandom_range(99) < 70) ? FRAC_DIGITS_DEF :
                               $urandom_range(6), fill)};
    end
    if ($urandom_range(99) < 8) begin
      k = $urandom_range(s.len());
      s = {s.substr(0, k - 1), $sformatf("%c", rand_printable()), s.substr(k, s.len() - 1)};
    end
    return s;
  endfunction

  function automatic string rand_hemi();
    case ($urandom_range(9))
      0: return "N";
      1: return "S";
      2: return "E";
      3: return "W";
      4: return "";
      5: return "Sx";
      6: return "s";
      7: return "Wn";
      8: return $sformatf("%c", rand_printable());
      default: return ($urandom_range(1) != 0) ? "S" : "W";
    endcase
  endfunction

  // sentence body between the dollar and the star
  function automatic string rand_body();
    string s;
    string hdr;
    int    r;
    int    extra;
    r = $urandom_range(99);
    if (r < 85) begin
      hdr = "GPGGA";
    end else begin
      case (r % 5)
        0: hdr = "GPRMC";
        1: hdr = "GPGG";
        2: hdr = "GPGGAA";
        3: hdr = "gpgga";
        default: hdr = "";
      endcase
    end
    s = {hdr, ",", rand_digits($urandom_range(6), FILL_RANDOM), ",", rand_coord(4), ",",
         rand_hemi()};
    // occasionally the sentence stops right after the latitude
    if ($urandom_range(99) < 6) return s;
    s = {s, ",", rand_coord(5), ",", rand_hemi()};
    extra = ($urandom_range(99) < 8) ? $urandom_range(20, 10) : $urandom_range(8);
    repeat (extra) s = {s, ",", rand_digits($urandom_range(3), FILL_RANDOM)};
    return s;
  endfunction

  // full sentence: dollar, body, checksum tail in the given style, line end
  task automatic send_gga(input string body, input cks_style_e style, input logic [7:0] term);
    logic [7:0] sum;
    string      tail;
    int         i;
    sum = '0;
    for (i = 0; i < body.len(); i++) sum ^= body[i];
    case (style)
      CKS_UPPER: tail = {"*", hex_text(sum, 1'b0)};
      CKS_LOWER: tail = {"*", hex_text(sum, 1'b1)};
      CKS_WRONG: tail = {"*", hex_text(sum ^ 8'($urandom_range(255, 1)), 1'b0)};
      CKS_ONE:   tail = $sformatf("*%c", hex_digit(sum[3:0], 1'b0));
      CKS_THREE: tail = {"*", hex_text(sum, 1'b0), "0"};
      CKS_JUNK:  tail = $sformatf("*%cG", hex_digit(sum[7:4], 1'b0));
      default:   tail = "";
    endcase
    send_text({"$", body, tail});
    send_byte(term);
    // a trailing lf after cr lands while waiting for a dollar
    if (term == CH_CR && $urandom_range(1) != 0) send_byte(CH_LF);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned goal;
    int          r;
    cks_style_e  style;
    goal = sent_count + n;
    while (sent_count < goal) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_noise($urandom_range(12, 1));
      end else if (r < 15) begin
        // abandoned sentence, the next dollar drops it
        send_text({"$", rand_body()});
      end else if (r < 22) begin
        send_gga("GPGGA", ($urandom_range(1) != 0) ? CKS_UPPER : CKS_WRONG, CH_LF);
      end else begin
        r = $urandom_range(99);
        style = (r < 45) ? CKS_UPPER : (r < 80) ? CKS_LOWER : (r < 86) ? CKS_WRONG :
                (r < 90) ? CKS_ONE : (r < 93) ? CKS_THREE : (r < 96) ? CKS_JUNK : CKS_NONE;
        send_gga(rand_body(), style, ($urandom_range(1) != 0) ? CH_CR : CH_LF);
      end
    end
  endtask

  // stop offering and wait until every owed fix has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.fixes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sentences, no idling on either side
    idle_pct  = 0;
    stall_pct = 0;
    send_byte(CH_CR);                                 // line end while waiting
    send_byte(CH_LF);
    send_text("xyz");
    send_gga("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", CKS_UPPER,
             CH_CR);
    // largest magnitudes, south and west
    send_gga("GPGGA,235959,9999.9999,S,99999.9999,W,2,12,1.0,0.0,M,0.0,M,,", CKS_LOWER,
             CH_LF);
    send_gga("GPGGA,000000,0000.0000,N,00000.0000,E,0,00,,,,,,,", CKS_UPPER, CH_CR);
    send_gga("GPGGA,,,,,,,,,,,,,,", CKS_UPPER, CH_LF);                 // all fields empty
    send_gga("GPGGA,123519,4807.038,N,01131.000,E", CKS_WRONG, CH_CR);
    send_gga("GPGGA,123519,4807.038,N,01131.000,E", CKS_NONE, CH_LF);  // no star
    send_gga("GPRMC,123519,4807.038,N,01131.000,E", CKS_UPPER, CH_CR);
    send_gga("GPGG,1,4807.038,N,01131.000,E", CKS_UPPER, CH_LF);
    send_gga("GPGGAA,1,4807.038,N,01131.000,E", CKS_UPPER, CH_LF);
    // field counter saturation
    send_gga("GPGGA,1,4807.5,S,01131.5,W,a,b,c,d,e,f,g,h,i,j,k,l,m,n,o", CKS_UPPER, CH_CR);
    // surplus digits, second point, junk inside numbers
    send_gga("GPGGA,1,123456.1234567,S,1234567.1234567,W", CKS_UPPER, CH_LF);
    send_gga("GPGGA,1,48a7.0.3,N,0-11.31.0,E", CKS_LOWER, CH_LF);
    // missing fraction digits
    send_gga("GPGGA,1,4807,S,01131,W", CKS_UPPER, CH_CR);
    send_gga("GPGGA,1,5,N,.5,E", CKS_UPPER, CH_LF);
    // only the first hemisphere letter counts, and only upper case
    send_gga("GPGGA,1,4807.1,sX,01131.1,WE", CKS_UPPER, CH_LF);
    send_gga("GPGGA,1,4807.1,,01131.1,w", CKS_UPPER, CH_LF);
    // malformed checksum tails
    send_gga("GPGGA,1,4807.1,N,01131.1,E", CKS_ONE, CH_LF);
    send_gga("GPGGA,1,4807.1,N,01131.1,E", CKS_THREE, CH_CR);
    send_gga("GPGGA,1,4807.1,N,01131.1,E", CKS_JUNK, CH_LF);
    send_gga("GPGGA,1,4807.1234", CKS_UPPER, CH_LF);                  // ends after latitude
    // dollar in the body and in the checksum restarts the sentence
    send_text("$GPGGA,12,48");
    send_gga("GPGGA,1,4807.1,S,01131.1,E", CKS_UPPER, CH_LF);
    send_text("$GPGGA,1,1,N,1,E*4");
    send_gga("GPGGA,1,1,N,1,W", CKS_LOWER, CH_CR);
    // high bytes inside a field, then a star within the checksum
    send_text("$GPGGA,1,");
    send_byte(8'hB5);
    send_byte(8'hFF);
    send_text(",N*00");
    send_byte(CH_CR);
    send_text("$GPGGA*00*");
    send_byte(CH_LF);
    drain();

    // random sentences under each traffic shape
    random_traffic(140);
    idle_pct = 59;
    stall_pct = 0;
    random_traffic(140);
    idle_pct = 0;
    stall_pct = 59;
    random_traffic(140);
    idle_pct = 26;
    stall_pct = 26;
    random_traffic(140);
    drain();

    // receiver holds off while short sentences keep coming, so the record queue backs up
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (40) send_gga("GPGGA", CKS_UPPER, CH_LF);
    drain();

    if (sb.errors == 0 && sb.fixes_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
